// ----- rtl/core/rpn_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_pkg: shared types and constants for the RPN stack evaluator
// Token and status codes, controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package rpn_pkg;
	localparam int STACK_DEPTH_DEF = 16;
	localparam int FRAC_BITS_DEF   = 16;

	localparam logic [2:0] ACT_PUSH   = 3'd0;
	localparam logic [2:0] ACT_ADD    = 3'd1;
	localparam logic [2:0] ACT_SUB    = 3'd2;
	localparam logic [2:0] ACT_MUL    = 3'd3;
	localparam logic [2:0] ACT_DIV    = 3'd4;
	localparam logic [2:0] ACT_MOD    = 3'd5;
	localparam logic [2:0] ACT_FINISH = 3'd6;
	localparam logic [2:0] ACT_ILL    = 3'd7;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_DIV0     = 3'd1;
	localparam logic [2:0] ST_MOD0     = 3'd2;
	localparam logic [2:0] ST_UNDER    = 3'd3;
	localparam logic [2:0] ST_OVER     = 3'd4;
	localparam logic [2:0] ST_ILLEGAL  = 3'd5;
	localparam logic [2:0] ST_BADDEPTH = 3'd6;

	// controller -> datapath
	typedef struct packed {
		logic load_tok;   // capture token, issue stack reads
		logic load_ops;   // capture read data as operands
		logic start_div;  // start the divider
		logic div_step;   // one divider iteration
		logic mul_s1;     // register product
		logic write_res;  // write result to stack at depth-2
		logic push;       // write value at depth
		logic pop;        // depth--
		logic clear;      // depth=0, err=0
		logic set_err;
		logic [2:0] err;
	} rpn_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] action;
		logic       full;
		logic       few;      // fewer than two values
		logic       one;      // exactly one value
		logic       b_zero;
		logic       bi_zero;
		logic       div_done;
		logic [2:0] err;
	} rpn_sts_t;
endpackage
`default_nettype wire

// ----- rtl/core/rpn_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_if: valid/ready channel
// Generic payload carrier with source and sink views.
// ----------------------------------------------------------------------------
interface rpn_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/rpn_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_ram: generic RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module rpn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule
`default_nettype wire

// ----- rtl/core/rpn_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_div: iterative unsigned divider
// Restoring division, one quotient bit per step, NB steps.
// ----------------------------------------------------------------------------
module rpn_div #(
	parameter int NB = 48
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          step,
	input  wire logic [NB-1:0] num,
	input  wire logic [31:0]   den,
	output logic      [NB-1:0] quo,
	output logic               done
);
	localparam int CW = $clog2(NB + 1);
	logic [NB-1:0] q_q;
	logic [32:0]   r_q;
	logic [31:0]   d_q;
	logic [CW-1:0] cnt_q;
	logic [32:0]   trial;
	logic [32:0]   diff;

	assign trial = {r_q[31:0], q_q[NB-1]};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NB);
		end else if (step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (step && cnt_q != '0) begin
			if (!diff[32]) begin
				r_q <= diff;
				q_q <= {q_q[NB-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[NB-2:0], 1'b0};
			end
		end
	end

	assign quo  = q_q;
	assign done = (cnt_q == '0);
endmodule
`default_nettype wire

// ----- rtl/core/rpn_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_dp: evaluator datapath
// Operand stack, depth and error registers, arithmetic units, result format.
// ----------------------------------------------------------------------------
module rpn_dp #(
	parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
	parameter int FRAC_BITS   = rpn_pkg::FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [2:0]         in_action,
	input  wire logic [31:0]        in_value,
	input  wire rpn_pkg::rpn_cmd_t  cmd,
	output rpn_pkg::rpn_sts_t       sts,
	output logic [31:0]             top0,
	output logic [4:0]              depth_out
);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int NB = 32 + FRAC_BITS;

	logic [DW-1:0] depth_q;
	logic [2:0]    err_q;
	logic [2:0]    act_q;
	logic [31:0]   val_q;
	logic signed [31:0] a_q, b_q;
	logic signed [63:0] prod_s1;
	logic [31:0]   ra, rb;
	logic [DW-1:0] dm1, dm2;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	logic          we;
	logic signed [31:0] res;

	assign dm1 = depth_q - 1'b1;
	assign dm2 = depth_q - DW'(2);

	// divider operands
	logic [31:0]   mag_a, mag_b;
	logic [NB-1:0] num;
	logic [NB-1:0] quo;
	logic          div_done;
	assign mag_a = a_q[31] ? 32'(-a_q) : a_q;
	assign mag_b = b_q[31] ? 32'(-b_q) : b_q;
	assign num   = NB'(mag_a) << FRAC_BITS;

	// modulo integer parts (truncated toward zero)
	logic [31:0] ia, ib;
	assign ia = mag_a >> FRAC_BITS;
	assign ib = mag_b >> FRAC_BITS;

	rpn_div #(.NB(NB)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.start_div), .step(cmd.div_step),
		.num(act_q == rpn_pkg::ACT_MOD ? NB'(ia) : num),
		.den(act_q == rpn_pkg::ACT_MOD ? ib : mag_b),
		.quo(quo), .done(div_done)
	);

	// remainder for modulo: |a| - q*|b| on integer parts
	logic [31:0] rem_i;
	logic [31:0] qb_s1;
	always_ff @(posedge clk) begin
		if (cmd.mul_s1) begin
			prod_s1 <= 64'(a_q) * 64'(b_q);
			qb_s1   <= quo[31:0] * ib;
		end
	end
	assign rem_i = ia - qb_s1;

	function automatic logic signed [31:0] sat(input logic signed [NB+1:0] x);
		logic signed [NB+1:0] mx, mn;
		mx = (NB+2)'(32'sh7fffffff);
		mn = -(NB+2)'(33'sh80000000) ;
		if (x > mx) return 32'sh7fffffff;
		if (x < mn) return 32'sh80000000;
		return x[31:0];
	endfunction

	logic signed [NB+1:0] sum_w, dif_w, mul_w, div_w, mod_w;
	logic signed [63:0]   mshift;
	logic signed [NB+1:0] qs;
	logic signed [NB+1:0] rs;
	assign sum_w  = (NB+2)'(a_q) + (NB+2)'(b_q);
	assign dif_w  = (NB+2)'(a_q) - (NB+2)'(b_q);
	assign mshift = prod_s1 >>> FRAC_BITS;
	assign mul_w  = (mshift > 64'sh7fffffff) ? (NB+2)'(32'sh7fffffff) :
	                (mshift < -64'sh80000000) ? {{(NB-30){1'b1}}, 32'h0} :
	                (NB+2)'(mshift);
	assign qs     = (NB+2)'({2'b00, quo});
	assign div_w  = (a_q[31] ^ b_q[31]) ? -qs : qs;
	assign rs     = (NB+2)'({1'b0, rem_i}) <<< FRAC_BITS;
	assign mod_w  = a_q[31] ? -rs : rs;

	always_comb begin
		unique case (act_q)
			rpn_pkg::ACT_ADD: res = sat(sum_w);
			rpn_pkg::ACT_SUB: res = sat(dif_w);
			rpn_pkg::ACT_MUL: res = sat(mul_w);
			rpn_pkg::ACT_DIV: res = sat(div_w);
			default:          res = sat(mod_w);
		endcase
	end

	assign we    = cmd.push || cmd.write_res;
	assign waddr = cmd.push ? depth_q[AW-1:0] : dm2[AW-1:0];
	assign wdata = cmd.push ? val_q : res;

	rpn_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr_a(cmd.load_tok ? dm2[AW-1:0] : '0),
		.raddr_b(dm1[AW-1:0]), .rdata_a(ra), .rdata_b(rb)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_tok) begin
			act_q <= in_action;
			val_q <= in_value;
		end
		if (cmd.load_ops) begin
			a_q <= ra;
			b_q <= rb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			err_q   <= rpn_pkg::ST_OK;
		end else if (cmd.clear) begin
			depth_q <= '0;
			err_q   <= rpn_pkg::ST_OK;
		end else begin
			if (cmd.set_err) err_q <= cmd.err;
			if (cmd.push) depth_q <= depth_q + 1'b1;
			else if (cmd.pop) depth_q <= dm1;
		end
	end

	// address 0 is read whenever load_tok is low, so ra holds entry 0 at finish
	assign top0 = ra;
	assign depth_out = 5'(depth_q);

	assign sts.action   = act_q;
	assign sts.full     = (depth_q >= DW'(STACK_DEPTH));
	assign sts.few      = (depth_q < DW'(2));
	assign sts.one      = (depth_q == DW'(1));
	assign sts.b_zero   = (b_q == '0);
	assign sts.bi_zero  = (ib == '0);
	assign sts.div_done = div_done;
	assign sts.err      = err_q;
endmodule
`default_nettype wire

// ----- rtl/core/rpn_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_ctrl: evaluator controller
// Sequences one token: decode, operand read, arithmetic, write-back, respond.
// ----------------------------------------------------------------------------
module rpn_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire rpn_pkg::rpn_sts_t sts,
	output rpn_pkg::rpn_cmd_t      cmd,
	output logic                   fin_q
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_OPS  = 3'd2;
	localparam logic [2:0] S_EXE  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_WB   = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0] state_q, state_d;
	logic       fin_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		fin_d   = fin_q;
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				cmd.load_tok = 1'b1;
				state_d = S_DEC;
			end
			S_DEC: begin
				fin_d = (sts.action == rpn_pkg::ACT_FINISH);
				state_d = S_OUT;
				if (sts.action == rpn_pkg::ACT_FINISH) begin
					state_d = S_WB; // read data of entry 0 settles, then clear
				end else if (sts.err != rpn_pkg::ST_OK) begin
					state_d = S_OUT;
				end else if (sts.action == rpn_pkg::ACT_PUSH) begin
					if (sts.full) begin
						cmd.set_err = 1'b1; cmd.err = rpn_pkg::ST_OVER;
					end else cmd.push = 1'b1;
				end else if (sts.action == rpn_pkg::ACT_ILL) begin
					cmd.set_err = 1'b1; cmd.err = rpn_pkg::ST_ILLEGAL;
				end else if (sts.few) begin
					cmd.set_err = 1'b1; cmd.err = rpn_pkg::ST_UNDER;
				end else begin
					cmd.load_ops = 1'b1;
					state_d = S_OPS;
				end
			end
			S_OPS: begin
				if (sts.action == rpn_pkg::ACT_DIV && sts.b_zero) begin
					cmd.set_err = 1'b1; cmd.err = rpn_pkg::ST_DIV0;
					state_d = S_OUT;
				end else if (sts.action == rpn_pkg::ACT_MOD && sts.bi_zero) begin
					cmd.set_err = 1'b1; cmd.err = rpn_pkg::ST_MOD0;
					state_d = S_OUT;
				end else if (sts.action == rpn_pkg::ACT_DIV ||
				             sts.action == rpn_pkg::ACT_MOD) begin
					cmd.start_div = 1'b1;
					state_d = S_DIV;
				end else begin
					cmd.mul_s1 = 1'b1;
					state_d = S_EXE;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					cmd.div_step = 1'b0;
					cmd.mul_s1 = 1'b1;
					state_d = S_EXE;
				end
			end
			S_EXE: begin
				cmd.write_res = 1'b1;
				cmd.pop = 1'b1;
				state_d = S_OUT;
			end
			S_WB: state_d = S_OUT;
			S_OUT: if (out_ready) begin
				if (fin_q) cmd.clear = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			fin_q   <= fin_d;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/rpn_stack_evaluator_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_top: RPN stack calculator
// Postfix evaluator on a signed fixed-point operand stack.
// ----------------------------------------------------------------------------
// One token at a time. Push tokens and tokens that only report or set a
// sticky, illegal, underflow or overflow error go from decode to respond;
// finish first waits for entry 0; a zero divisor is caught at operand read;
// add, subtract and multiply run operand read and arithmetic; divide and
// modulo also run the one-bit-per-cycle restoring divider. One result per
// token; a finish result reports the stack depth after clearing (0).
module rpn_stack_evaluator_top #(
	parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
	parameter int FRAC_BITS   = rpn_pkg::FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	rpn_if.sink      in_ch,
	rpn_if.source    out_ch
);
	rpn_pkg::rpn_cmd_t cmd;
	rpn_pkg::rpn_sts_t sts;
	logic [31:0] top0;
	logic [4:0]  depth;
	logic        fin;

	rpn_dp #(.STACK_DEPTH(STACK_DEPTH), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_action(in_ch.data[34:32]), .in_value(in_ch.data[31:0]),
		.cmd(cmd), .sts(sts), .top0(top0), .depth_out(depth)
	);

	rpn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd), .fin_q(fin)
	);

	logic [2:0]  status;
	logic [31:0] result;
	logic        ok_fin;
	assign ok_fin = fin && sts.err == rpn_pkg::ST_OK && sts.one;
	assign status = !fin ? sts.err :
	                (sts.err != rpn_pkg::ST_OK) ? sts.err :
	                ok_fin ? rpn_pkg::ST_OK : rpn_pkg::ST_BADDEPTH;
	assign result = ok_fin ? top0 : 32'h0;

	// payload: {status, result, depth, final_res}; depth after finish is 0
	assign out_ch.data = {status, result, (fin ? 5'd0 : depth), fin};
endmodule
`default_nettype wire
